@@ hdl/i2cra_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C register access master - shared definitions
// Bus phases, command and register codes, and the sequencer state record
// that passes between the top level and the step logic.
// ----------------------------------------------------------------------------
package i2cra_pkg;

   // Command codes carried in the op field
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Configuration register indexes
   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_HALF_PERIOD    = 1'b1;

   // Configuration reset values
   localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'h40;
   localparam logic [15:0] HALF_PERIOD_RESET    = 16'd10;

   // Bus sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_ST_A,
      PH_ST_B,
      PH_BIT_LO,
      PH_BIT_HI,
      PH_RS_A,
      PH_RS_B,
      PH_RS_C,
      PH_SP_A,
      PH_SP_B,
      PH_SP_C
   } phase_type;

   // Sequencer state
   typedef struct packed {
      phase_type   phase;
      logic [15:0] tick_count;
      logic [3:0]  bit_index;
      logic [2:0]  byte_index;
      logic [7:0]  shift_byte;
      logic        is_read;
      logic [7:0]  held_register;
      logic [15:0] held_value;
      logic [15:0] captured_data;
      logic        nack_flag;
      logic        scl_level;
      logic        sda_level;
   } seq_state_type;

   localparam seq_state_type SEQ_STATE_RESET = '{
      phase:         PH_IDLE,
      tick_count:    16'd0,
      bit_index:     4'd0,
      byte_index:    3'd0,
      shift_byte:    8'd0,
      is_read:       1'b0,
      held_register: 8'd0,
      held_value:    16'd0,
      captured_data: 16'd0,
      nack_flag:     1'b0,
      scl_level:     1'b1,
      sda_level:     1'b1
   };

   // Result of one tick
   typedef struct packed {
      logic        scl_out;
      logic        sda_out;
      logic        busy_res;
      logic        done_res;
      logic [15:0] read_data;
      logic        nack_seen;
   } tick_result_type;

endpackage

@@ hdl/i2cra_if.sv @@
// ----------------------------------------------------------------------------
// I2C register access master - channel interfaces
// Valid/ready channels for tick commands, tick results and register writes.
// ----------------------------------------------------------------------------
interface i2cra_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [7:0]  reg_addr;
   logic [15:0] write_value;
   logic        sda_in;

   modport source (output valid, op, reg_addr, write_value, sda_in, input ready);
   modport sink   (input valid, op, reg_addr, write_value, sda_in, output ready);
endinterface

interface i2cra_rsp_if;
   logic        valid;
   logic        ready;
   logic        scl_out;
   logic        sda_out;
   logic        busy_res;
   logic        done_res;
   logic [15:0] read_data;
   logic        nack_seen;

   modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data,
                   nack_seen, input ready);
   modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_data,
                   nack_seen, output ready);
endinterface

interface i2cra_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/i2cra_step.sv @@
// ----------------------------------------------------------------------------
// I2C register access master - tick step logic
// Computes the sequencer state after one tick and the bus levels and status
// that the tick produces.
// ----------------------------------------------------------------------------
module i2cra_step (
   input  i2cra_pkg::seq_state_type   cur,
   input  logic [6:0]                 device_address,
   input  logic [15:0]                half_period,
   input  logic [1:0]                 op,
   input  logic [7:0]                 reg_addr,
   input  logic [15:0]                write_value,
   input  logic                       sda_in,
   output i2cra_pkg::seq_state_type   nxt,
   output i2cra_pkg::tick_result_type res
);
   import i2cra_pkg::*;

   logic [15:0] step_ticks;
   logic        start;
   logic        last;
   logic        master_sends;
   logic        enter_sends;
   logic        do_start;
   logic        do_enter;
   phase_type   enter_phase;
   logic        done;
   logic        scl_now;
   logic        sda_now;

   // Byte the master shifts out next
   function automatic logic [7:0] byte_to_send(
      input logic [2:0]  by,
      input logic        rd,
      input logic [6:0]  dev,
      input logic [7:0]  hreg,
      input logic [15:0] hval
   );
      logic [7:0] b;
      case (by)
         3'd0:    b = {dev, 1'b0};
         3'd1:    b = hreg;
         3'd2:    b = rd ? {dev, 1'b1} : hval[15:8];
         3'd3:    b = rd ? 8'd0 : hval[7:0];
         default: b = 8'd0;
      endcase
      return b;
   endfunction

   assign step_ticks = (half_period == 16'd0) ? 16'd1 : half_period;

   always_comb begin
      nxt         = cur;
      done        = 1'b0;
      do_start    = 1'b0;
      do_enter    = 1'b0;
      enter_phase = PH_IDLE;

      // Take a new command only when idle
      start = (cur.phase == PH_IDLE) && ((op == OP_WRITE) || (op == OP_READ));
      if (start) begin
         nxt.is_read       = (op == OP_READ);
         nxt.held_register = reg_addr;
         nxt.held_value    = (op == OP_READ) ? 16'd0 : write_value;
         nxt.nack_flag     = 1'b0;
         nxt.byte_index    = 3'd0;
         nxt.bit_index     = 4'd0;
         nxt.shift_byte    = 8'd0;
         nxt.phase         = PH_ST_A;
         nxt.tick_count    = 16'd0;
         nxt.scl_level     = 1'b1;
         nxt.sda_level     = 1'b1;
      end

      scl_now      = nxt.scl_level;
      sda_now      = nxt.sda_level;
      last         = ({1'b0, nxt.tick_count} + 17'd1) >= {1'b0, step_ticks};
      master_sends = !nxt.is_read || (nxt.byte_index < 3'd3);

      if (nxt.phase != PH_IDLE) begin
         // Sample SDA on the last tick of the high phase
         if ((nxt.phase == PH_BIT_HI) && last) begin
            if (master_sends) begin
               if ((nxt.bit_index >= 4'd8) && sda_in)
                  nxt.nack_flag = 1'b1;
            end else if (nxt.bit_index < 4'd8) begin
               nxt.shift_byte = {nxt.shift_byte[6:0], sda_in};
            end
         end

         if (!last) begin
            nxt.tick_count = nxt.tick_count + 16'd1;
         end else begin
            case (nxt.phase)
               PH_ST_A: begin
                  do_enter    = 1'b1;
                  enter_phase = PH_ST_B;
               end
               PH_ST_B: begin
                  nxt.byte_index = 3'd0;
                  do_start       = 1'b1;
               end
               PH_BIT_LO: begin
                  do_enter    = 1'b1;
                  enter_phase = PH_BIT_HI;
               end
               PH_BIT_HI: begin
                  if ((nxt.bit_index < 4'd8) && master_sends)
                     nxt.shift_byte = {nxt.shift_byte[6:0], 1'b0};
                  nxt.bit_index = nxt.bit_index + 4'd1;
                  if (nxt.bit_index <= 4'd8) begin
                     do_enter    = 1'b1;
                     enter_phase = PH_BIT_LO;
                  end else begin
                     // Byte finished: keep received data, move to next byte
                     if (!master_sends)
                        nxt.held_value = {nxt.held_value[7:0], nxt.shift_byte};
                     nxt.byte_index = nxt.byte_index + 3'd1;
                     if (!nxt.is_read) begin
                        if (nxt.byte_index >= 3'd4) begin
                           do_enter    = 1'b1;
                           enter_phase = PH_SP_A;
                        end else begin
                           do_start = 1'b1;
                        end
                     end else if (nxt.byte_index == 3'd2) begin
                        do_enter    = 1'b1;
                        enter_phase = PH_RS_A;
                     end else if (nxt.byte_index >= 3'd5) begin
                        do_enter    = 1'b1;
                        enter_phase = PH_SP_A;
                     end else begin
                        do_start = 1'b1;
                     end
                  end
               end
               PH_RS_A: begin
                  do_enter    = 1'b1;
                  enter_phase = PH_RS_B;
               end
               PH_RS_B: begin
                  do_enter    = 1'b1;
                  enter_phase = PH_RS_C;
               end
               PH_RS_C: begin
                  do_start = 1'b1;
               end
               PH_SP_A: begin
                  do_enter    = 1'b1;
                  enter_phase = PH_SP_B;
               end
               PH_SP_B: begin
                  do_enter    = 1'b1;
                  enter_phase = PH_SP_C;
               end
               default: begin
                  // Stop complete
                  if (nxt.is_read)
                     nxt.captured_data = nxt.held_value;
                  done        = 1'b1;
                  do_enter    = 1'b1;
                  enter_phase = PH_IDLE;
               end
            endcase
         end
      end

      // Load the next byte to shift
      if (do_start) begin
         nxt.bit_index  = 4'd0;
         nxt.shift_byte = byte_to_send(nxt.byte_index, nxt.is_read, device_address,
                                       nxt.held_register, nxt.held_value);
         do_enter       = 1'b1;
         enter_phase    = PH_BIT_LO;
      end

      // Enter a phase: restart the tick count and set the bus levels
      enter_sends = !nxt.is_read || (nxt.byte_index < 3'd3);
      if (do_enter) begin
         nxt.phase      = enter_phase;
         nxt.tick_count = 16'd0;
         case (enter_phase)
            PH_ST_A: begin
               nxt.scl_level = 1'b1;
               nxt.sda_level = 1'b1;
            end
            PH_ST_B: begin
               nxt.scl_level = 1'b1;
               nxt.sda_level = 1'b0;
            end
            PH_BIT_LO: begin
               nxt.scl_level = 1'b0;
               if (enter_sends)
                  nxt.sda_level = (nxt.bit_index < 4'd8) ? nxt.shift_byte[7] : 1'b1;
               else
                  nxt.sda_level = (nxt.bit_index < 4'd8) ? 1'b1 :
                                  ((nxt.byte_index == 3'd3) ? 1'b0 : 1'b1);
            end
            PH_BIT_HI: begin
               nxt.scl_level = 1'b1;
            end
            PH_RS_A: begin
               nxt.scl_level = 1'b0;
               nxt.sda_level = 1'b1;
            end
            PH_RS_B: begin
               nxt.scl_level = 1'b1;
               nxt.sda_level = 1'b1;
            end
            PH_RS_C: begin
               nxt.scl_level = 1'b1;
               nxt.sda_level = 1'b0;
            end
            PH_SP_A: begin
               nxt.scl_level = 1'b0;
               nxt.sda_level = 1'b0;
            end
            PH_SP_B: begin
               nxt.scl_level = 1'b1;
               nxt.sda_level = 1'b0;
            end
            PH_SP_C: begin
               nxt.scl_level = 1'b1;
               nxt.sda_level = 1'b1;
            end
            default: begin
               nxt.phase     = PH_IDLE;
               nxt.scl_level = 1'b1;
               nxt.sda_level = 1'b1;
            end
         endcase
      end

      res.scl_out   = scl_now;
      res.sda_out   = sda_now;
      res.busy_res  = (nxt.phase != PH_IDLE);
      res.done_res  = done;
      res.read_data = nxt.captured_data;
      res.nack_seen = nxt.nack_flag;
   end

endmodule

@@ hdl/i2c_register_access_master.sv @@
// ----------------------------------------------------------------------------
// I2C register access master
// Bit-level I2C master running 16-bit register writes and reads, one bus
// tick per request transaction.
// ----------------------------------------------------------------------------
// Each request transaction is one tick of the bus sequencer and yields one
// response transaction carrying the SCL/SDA drive levels for that tick and
// the status. One request is taken every clock cycle while no response
// waits or the sink takes the waiting one in the same cycle; the response
// is registered at acceptance. The rate is set by the single sequencer
// state register, which is updated once per accepted tick. Op write or
// read starts a transaction only while idle; every bus step lasts
// half_period ticks (zero counts as one). Configuration writes are
// accepted every cycle and apply to later ticks.
// ----------------------------------------------------------------------------
module i2c_register_access_master (
   input logic         clock,
   input logic         reset,
   i2cra_req_if.sink   req,
   i2cra_rsp_if.source rsp,
   i2cra_csr_if.sink   csr
);
   import i2cra_pkg::*;

   logic [6:0]      device_address_ff;
   logic [15:0]     half_period_ff;
   seq_state_type   state_ff;
   seq_state_type   state_in;
   tick_result_type result_in;
   tick_result_type result_ff;
   logic            rsp_valid_ff;
   logic            req_accept;

   // Configuration registers
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= DEVICE_ADDRESS_RESET;
         half_period_ff    <= HALF_PERIOD_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_DEVICE_ADDRESS: device_address_ff <= csr.data[6:0];
            CSR_HALF_PERIOD:    half_period_ff    <= csr.data;
            default:            ;
         endcase
      end
   end

   // Step logic for one tick
   i2cra_step u_step (
      .cur            (state_ff),
      .device_address (device_address_ff),
      .half_period    (half_period_ff),
      .op             (req.op),
      .reg_addr       (req.reg_addr),
      .write_value    (req.write_value),
      .sda_in         (req.sda_in),
      .nxt            (state_in),
      .res            (result_in)
   );

   // Accept when the output register is empty or being drained
   assign req.ready  = !rsp_valid_ff || rsp.ready;
   assign req_accept = req.valid && req.ready;

   // Advance the sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_STATE_RESET;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.scl_out   = result_ff.scl_out;
   assign rsp.sda_out   = result_ff.sda_out;
   assign rsp.busy_res  = result_ff.busy_res;
   assign rsp.done_res  = result_ff.done_res;
   assign rsp.read_data = result_ff.read_data;
   assign rsp.nack_seen = result_ff.nack_seen;

endmodule
